/* design/aim_pkg.sv */
// ----------------------------------------------------------------------------
// aim_pkg
// Shared constants for the affine matrix inverse pipeline.
// ----------------------------------------------------------------------------
package aim_pkg;

    localparam int WORD_BITS = 32;   // default word width of every field
    localparam int FRAC_BITS = 16;   // default number of fraction bits
    localparam int DIM       = 3;    // rows and columns of the linear part
    localparam int LANES     = 9;    // one lane per linear entry

endpackage

/* design/aim_det.sv */
// ----------------------------------------------------------------------------
// aim_det
// Cofactor and determinant front end: six register stages that form the nine
// cofactors, the determinant, and the magnitudes and signs for the dividers.
// ----------------------------------------------------------------------------
module aim_det #(
    parameter int W  = aim_pkg::WORD_BITS,
    parameter int F  = aim_pkg::FRAC_BITS,
    parameter int TW = 3 * aim_pkg::WORD_BITS
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                en,
    input  logic                in_v,
    input  logic signed [W-1:0] lin [aim_pkg::DIM][aim_pkg::DIM],
    input  logic [TW-1:0]       tag_in,
    output logic                out_v,
    output logic [3*W+2:0]      dmag,
    output logic                zero,
    output logic [2*W+2*F:0]    nmag [aim_pkg::LANES],
    output logic [aim_pkg::LANES-1:0] neg,
    output logic [TW-1:0]       tag_out
);

    localparam int L   = aim_pkg::LANES;
    localparam int PW  = 2 * W;
    localparam int CW  = 2 * W + 1;
    localparam int DTW = 3 * W + 1;
    localparam int DW  = 3 * W + 3;
    localparam int NW  = CW + 2 * F;
    localparam int ST  = 6;

    logic signed [PW-1:0]  pa_next [L];
    logic signed [PW-1:0]  pb_next [L];
    logic signed [PW-1:0]  pa_reg  [L];
    logic signed [PW-1:0]  pb_reg  [L];
    logic signed [W-1:0]   row0_reg [2][aim_pkg::DIM];
    logic [TW-1:0]         tag_reg [ST];
    logic signed [CW-1:0]  cof_next [L];
    logic signed [CW-1:0]  cof_reg [4][L];
    logic signed [2*W+1:0] lo_next [aim_pkg::DIM];
    logic signed [2*W+1:0] lo_reg  [aim_pkg::DIM];
    logic signed [PW-1:0]  hi_next [aim_pkg::DIM];
    logic signed [PW-1:0]  hi_reg  [aim_pkg::DIM];
    logic signed [DTW-1:0] term_next [aim_pkg::DIM];
    logic signed [DTW-1:0] term_reg  [aim_pkg::DIM];
    logic signed [DW-1:0]  det_next;
    logic signed [DW-1:0]  det_reg;
    logic [DW-1:0]         dmag_next;
    logic [DW-1:0]         dmag_reg;
    logic                  zero_reg;
    logic [NW-1:0]         nmag_next [L];
    logic [NW-1:0]         nmag_reg  [L];
    logic [L-1:0]          neg_next;
    logic [L-1:0]          neg_reg;
    logic [ST-1:0]         v_reg;

    // Products of the two-by-two minors, lane = row * 3 + column.
    always_comb
    begin
        pa_next[0] = lin[1][1] * lin[2][2];  pb_next[0] = lin[2][1] * lin[1][2];
        pa_next[1] = lin[2][1] * lin[0][2];  pb_next[1] = lin[0][1] * lin[2][2];
        pa_next[2] = lin[0][1] * lin[1][2];  pb_next[2] = lin[1][1] * lin[0][2];
        pa_next[3] = lin[2][0] * lin[1][2];  pb_next[3] = lin[1][0] * lin[2][2];
        pa_next[4] = lin[0][0] * lin[2][2];  pb_next[4] = lin[2][0] * lin[0][2];
        pa_next[5] = lin[1][0] * lin[0][2];  pb_next[5] = lin[0][0] * lin[1][2];
        pa_next[6] = lin[1][0] * lin[2][1];  pb_next[6] = lin[2][0] * lin[1][1];
        pa_next[7] = lin[2][0] * lin[0][1];  pb_next[7] = lin[0][0] * lin[2][1];
        pa_next[8] = lin[0][0] * lin[1][1];  pb_next[8] = lin[1][0] * lin[0][1];
    end

    always_comb
    begin
        for (int l = 0; l < L; l++)
        begin
            cof_next[l] = CW'(pa_reg[l]) - CW'(pb_reg[l]);
        end
    end

    // The 2W+1 bit cofactor is split so that each multiplier stays word sized.
    always_comb
    begin
        logic signed [W+1:0] clo;
        logic signed [W-1:0] chi;
        for (int j = 0; j < aim_pkg::DIM; j++)
        begin
            clo = {1'b0, cof_reg[0][3*j][W:0]};
            chi = cof_reg[0][3*j][CW-1:W+1];
            lo_next[j] = row0_reg[1][j] * clo;
            hi_next[j] = row0_reg[1][j] * chi;
        end
    end

    always_comb
    begin
        for (int j = 0; j < aim_pkg::DIM; j++)
        begin
            term_next[j] = (DTW'(hi_reg[j]) <<< (W + 1)) + DTW'(lo_reg[j]);
        end
        det_next = DW'(term_reg[0]) + DW'(term_reg[1]) + DW'(term_reg[2]);
    end

    always_comb
    begin
        logic [CW-1:0] cm;
        dmag_next = det_reg[DW-1] ? DW'(-det_reg) : DW'(det_reg);
        for (int l = 0; l < L; l++)
        begin
            cm = cof_reg[3][l][CW-1] ? CW'(-cof_reg[3][l]) : CW'(cof_reg[3][l]);
            nmag_next[l] = {cm, {(2*F){1'b0}}};
            neg_next[l]  = cof_reg[3][l][CW-1] ^ det_reg[DW-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pa_reg      <= pa_next;
            pb_reg      <= pb_next;
            row0_reg[0] <= lin[0];
            row0_reg[1] <= row0_reg[0];
            tag_reg[0]  <= tag_in;
            for (int s = 1; s < ST; s++)
            begin
                tag_reg[s] <= tag_reg[s-1];
            end
            cof_reg[0]  <= cof_next;
            for (int s = 1; s < 4; s++)
            begin
                cof_reg[s] <= cof_reg[s-1];
            end
            lo_reg      <= lo_next;
            hi_reg      <= hi_next;
            term_reg    <= term_next;
            det_reg     <= det_next;
            dmag_reg    <= dmag_next;
            zero_reg    <= (det_reg == '0);
            nmag_reg    <= nmag_next;
            neg_reg     <= neg_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (en)
        begin
            v_reg <= {v_reg[ST-2:0], in_v};
        end
    end

    assign out_v   = v_reg[ST-1];
    assign dmag    = dmag_reg;
    assign zero    = zero_reg;
    assign nmag    = nmag_reg;
    assign neg     = neg_reg;
    assign tag_out = tag_reg[ST-1];

endmodule

/* design/aim_div.sv */
// ----------------------------------------------------------------------------
// aim_div
// Nine-lane pipelined restoring divider with a shared divisor: one overflow
// stage, then one quotient bit per stage.
// ----------------------------------------------------------------------------
module aim_div #(
    parameter int W  = aim_pkg::WORD_BITS,
    parameter int NW = 2 * aim_pkg::WORD_BITS + 2 * aim_pkg::FRAC_BITS + 1,
    parameter int DW = 3 * aim_pkg::WORD_BITS + 3,
    parameter int TW = 3 * aim_pkg::WORD_BITS + 1
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      en,
    input  logic                      in_v,
    input  logic [NW-1:0]             nmag [aim_pkg::LANES],
    input  logic [aim_pkg::LANES-1:0] neg_in,
    input  logic [DW-1:0]             dmag,
    input  logic [TW-1:0]             tag_in,
    output logic                      out_v,
    output logic [W-1:0]              q [aim_pkg::LANES],
    output logic [aim_pkg::LANES-1:0] ovf,
    output logic [aim_pkg::LANES-1:0] neg_out,
    output logic [TW-1:0]             tag_out
);

    localparam int L  = aim_pkg::LANES;
    localparam int RW = ((NW > DW + W) ? NW : DW + W) + 1;
    localparam int ST = W + 1;

    logic [RW-1:0] r_next [ST][L];
    logic [RW-1:0] r_reg  [ST][L];
    logic [W-1:0]  q_next [ST][L];
    logic [W-1:0]  q_reg  [ST][L];
    logic [L-1:0]  ovf_next;
    logic [L-1:0]  ovf_reg [ST];
    logic [L-1:0]  neg_reg [ST];
    logic [DW-1:0] d_reg   [ST];
    logic [TW-1:0] tag_reg [ST];
    logic [ST-1:0] v_reg;

    // The first stage flags quotients of 2^W or more; every later stage
    // settles one quotient bit, most significant first.
    always_comb
    begin
        logic [RW-1:0] sub;
        logic          ge;
        for (int l = 0; l < L; l++)
        begin
            r_next[0][l] = RW'(nmag[l]);
            q_next[0][l] = '0;
            ovf_next[l]  = RW'(nmag[l]) >= (RW'(dmag) << W);
        end
        for (int s = 1; s < ST; s++)
        begin
            for (int l = 0; l < L; l++)
            begin
                sub = RW'(d_reg[s-1]) << (W - s);
                ge  = r_reg[s-1][l] >= sub;
                r_next[s][l] = ge ? (r_reg[s-1][l] - sub) : r_reg[s-1][l];
                q_next[s][l] = q_reg[s-1][l] | (W'(ge) << (W - s));
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            r_reg      <= r_next;
            q_reg      <= q_next;
            ovf_reg[0] <= ovf_next;
            neg_reg[0] <= neg_in;
            d_reg[0]   <= dmag;
            tag_reg[0] <= tag_in;
            for (int s = 1; s < ST; s++)
            begin
                ovf_reg[s] <= ovf_reg[s-1];
                neg_reg[s] <= neg_reg[s-1];
                d_reg[s]   <= d_reg[s-1];
                tag_reg[s] <= tag_reg[s-1];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (en)
        begin
            v_reg <= {v_reg[ST-2:0], in_v};
        end
    end

    assign out_v   = v_reg[ST-1];
    assign q       = q_reg[ST-1];
    assign ovf     = ovf_reg[ST-1];
    assign neg_out = neg_reg[ST-1];
    assign tag_out = tag_reg[ST-1];

    // In lane 0, a finished word that did not overflow leaves a remainder below a nonzero divisor.
    a_rem_below_div: assert property (@(posedge clk) disable iff (!rst_n)
        v_reg[ST-1] && (d_reg[ST-1] != '0) && !ovf_reg[ST-1][0]
        |-> r_reg[ST-1][0] < RW'(d_reg[ST-1]))
        else $error("divider remainder not reduced below divisor");

endmodule

/* design/aim_tail.sv */
// ----------------------------------------------------------------------------
// aim_tail
// Saturates the linear entries (or zeroes them for a singular matrix), then forms the
// negated dot product, scaled back, truncated toward zero and saturated.
// ----------------------------------------------------------------------------
module aim_tail #(
    parameter int W  = aim_pkg::WORD_BITS,
    parameter int F  = aim_pkg::FRAC_BITS,
    parameter int TW = 3 * aim_pkg::WORD_BITS + 1
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      en,
    input  logic                      in_v,
    input  logic [W-1:0]              q [aim_pkg::LANES],
    input  logic [aim_pkg::LANES-1:0] ovf,
    input  logic [aim_pkg::LANES-1:0] neg,
    input  logic [TW-1:0]             tag_in,
    output logic                      out_v,
    output logic signed [W-1:0]       inv [aim_pkg::LANES],
    output logic signed [W-1:0]       shift [aim_pkg::DIM]
);

    localparam int L  = aim_pkg::LANES;
    localparam int D  = aim_pkg::DIM;
    localparam int PW = 2 * W;
    localparam int XW = 2 * W + 3;
    localparam logic [W-1:0] MAXW = {1'b0, {(W-1){1'b1}}};
    localparam logic [W-1:0] MINW = {1'b1, {(W-1){1'b0}}};

    logic signed [W-1:0]  inv1_next [L];
    logic signed [W-1:0]  inv1_reg  [L];
    logic signed [W-1:0]  inv2_reg  [L];
    logic signed [W-1:0]  inv3_reg  [L];
    logic signed [W-1:0]  t_next    [D];
    logic signed [W-1:0]  t1_reg    [D];
    logic signed [PW-1:0] prod_next [D][D];
    logic signed [PW-1:0] prod_reg  [D][D];
    logic signed [W-1:0]  sh_next   [D];
    logic signed [W-1:0]  sh_reg    [D];
    logic [2:0]           v_reg;

    always_comb
    begin
        for (int l = 0; l < L; l++)
        begin
            if (tag_in[TW-1])
            begin
                inv1_next[l] = '0;
            end
            else if (neg[l])
            begin
                inv1_next[l] = (ovf[l] || (q[l] > MINW)) ? MINW : -q[l];
            end
            else
            begin
                inv1_next[l] = (ovf[l] || (q[l] >= MINW)) ? MAXW : q[l];
            end
        end
        for (int j = 0; j < D; j++)
        begin
            t_next[j] = tag_in[j*W +: W];
        end
    end

    always_comb
    begin
        for (int i = 0; i < D; i++)
        begin
            for (int j = 0; j < D; j++)
            begin
                prod_next[i][j] = t1_reg[j] * inv1_reg[i*D+j];
            end
        end
    end

    // Negate, divide by 2^F toward zero, then clamp to the word range.
    always_comb
    begin
        logic signed [XW-1:0] xs;
        logic signed [XW-1:0] xb;
        logic signed [XW-1:0] y;
        for (int i = 0; i < D; i++)
        begin
            xs = -(XW'(prod_reg[i][0]) + XW'(prod_reg[i][1]) + XW'(prod_reg[i][2]));
            xb = xs[XW-1] ? (xs + XW'((1 << F) - 1)) : xs;
            y  = xb >>> F;
            if ((&y[XW-1:W-1]) || !(|y[XW-1:W-1]))
            begin
                sh_next[i] = y[W-1:0];
            end
            else
            begin
                sh_next[i] = y[XW-1] ? MINW : MAXW;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            inv1_reg <= inv1_next;
            t1_reg   <= t_next;
            inv2_reg <= inv1_reg;
            prod_reg <= prod_next;
            inv3_reg <= inv2_reg;
            sh_reg   <= sh_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (en)
        begin
            v_reg <= {v_reg[1:0], in_v};
        end
    end

    assign out_v = v_reg[2];
    assign inv   = inv3_reg;
    assign shift = sh_reg;

    a_singular_zero: assert property (@(posedge clk) disable iff (!rst_n)
        en && in_v && tag_in[TW-1]
        |=> (inv1_reg[0] == '0) && (inv1_reg[4] == '0) && (inv1_reg[8] == '0))
        else $error("singular matrix gave a nonzero diagonal");

    a_ovf_pos_max: assert property (@(posedge clk) disable iff (!rst_n)
        en && in_v && !tag_in[TW-1] && ovf[0] && !neg[0] |=> inv1_reg[0] == MAXW)
        else $error("positive overflow not saturated");

    a_ovf_neg_min: assert property (@(posedge clk) disable iff (!rst_n)
        en && in_v && !tag_in[TW-1] && ovf[0] && neg[0] |=> inv1_reg[0] == MINW)
        else $error("negative overflow not saturated");

endmodule

/* design/affine_matrix_inverse.sv */
// ----------------------------------------------------------------------------
// affine_matrix_inverse
// Inverse of a 3x4 affine transform in signed fixed point.
// ----------------------------------------------------------------------------
// The block takes one matrix word per clock and returns one inverse word per
// clock once the pipeline has filled and the output is not stalled. Six stages
// form the cofactors and the determinant, WORD_BITS + 1 stages of the
// nine-lane divider produce one quotient bit each, and three stages saturate
// the linear part and compute the translation. Each linear entry is cofactor
// over determinant, truncated toward zero and saturated; each translation
// entry is the negated dot product of the input translation with the
// saturated inverse row, divided back by 2^FRAC_BITS toward zero and
// saturated. A matrix with zero determinant returns an all-zero word. The
// whole pipeline advances together; it holds while a finished word waits to
// be taken, and in_ready follows out_ready combinationally.
// ----------------------------------------------------------------------------
module affine_matrix_inverse #(
    parameter int WORD_BITS = aim_pkg::WORD_BITS,
    parameter int FRAC_BITS = aim_pkg::FRAC_BITS
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic signed [WORD_BITS-1:0] row0_col0,
    input  logic signed [WORD_BITS-1:0] row0_col1,
    input  logic signed [WORD_BITS-1:0] row0_col2,
    input  logic signed [WORD_BITS-1:0] row0_shift,
    input  logic signed [WORD_BITS-1:0] row1_col0,
    input  logic signed [WORD_BITS-1:0] row1_col1,
    input  logic signed [WORD_BITS-1:0] row1_col2,
    input  logic signed [WORD_BITS-1:0] row1_shift,
    input  logic signed [WORD_BITS-1:0] row2_col0,
    input  logic signed [WORD_BITS-1:0] row2_col1,
    input  logic signed [WORD_BITS-1:0] row2_col2,
    input  logic signed [WORD_BITS-1:0] row2_shift,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic signed [WORD_BITS-1:0] inv_row0_col0,
    output logic signed [WORD_BITS-1:0] inv_row0_col1,
    output logic signed [WORD_BITS-1:0] inv_row0_col2,
    output logic signed [WORD_BITS-1:0] inv_row0_shift,
    output logic signed [WORD_BITS-1:0] inv_row1_col0,
    output logic signed [WORD_BITS-1:0] inv_row1_col1,
    output logic signed [WORD_BITS-1:0] inv_row1_col2,
    output logic signed [WORD_BITS-1:0] inv_row1_shift,
    output logic signed [WORD_BITS-1:0] inv_row2_col0,
    output logic signed [WORD_BITS-1:0] inv_row2_col1,
    output logic signed [WORD_BITS-1:0] inv_row2_col2,
    output logic signed [WORD_BITS-1:0] inv_row2_shift
);

    localparam int W  = WORD_BITS;
    localparam int F  = FRAC_BITS;
    localparam int L  = aim_pkg::LANES;
    localparam int D  = aim_pkg::DIM;
    localparam int DW = 3 * W + 3;          // determinant magnitude
    localparam int NW = 2 * W + 2 * F + 1;  // scaled cofactor magnitude
    localparam int TW = 3 * W;              // translation column

    logic                en;
    logic signed [W-1:0] lin [D][D];
    logic [TW-1:0]       trans;

    logic                det_v;
    logic [DW-1:0]       det_dmag;
    logic                det_zero;
    logic [NW-1:0]       det_nmag [L];
    logic [L-1:0]        det_neg;
    logic [TW-1:0]       det_tag;

    logic                div_v;
    logic [W-1:0]        div_q [L];
    logic [L-1:0]        div_ovf;
    logic [L-1:0]        div_neg;
    logic [TW:0]         div_tag;

    logic signed [W-1:0] inv [L];
    logic signed [W-1:0] shift [D];

    // Every stage moves on when the output register is free or being emptied.
    assign en       = !out_valid || out_ready;
    assign in_ready = en;

    assign lin[0][0] = row0_col0;
    assign lin[0][1] = row0_col1;
    assign lin[0][2] = row0_col2;
    assign lin[1][0] = row1_col0;
    assign lin[1][1] = row1_col1;
    assign lin[1][2] = row1_col2;
    assign lin[2][0] = row2_col0;
    assign lin[2][1] = row2_col1;
    assign lin[2][2] = row2_col2;
    assign trans     = {row2_shift, row1_shift, row0_shift};

    aim_det #(
        .W  (W),
        .F  (F),
        .TW (TW)
    ) u_det (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .in_v    (in_valid),
        .lin     (lin),
        .tag_in  (trans),
        .out_v   (det_v),
        .dmag    (det_dmag),
        .zero    (det_zero),
        .nmag    (det_nmag),
        .neg     (det_neg),
        .tag_out (det_tag)
    );

    // The singular flag rides above the translation column through the divider.
    aim_div #(
        .W  (W),
        .NW (NW),
        .DW (DW),
        .TW (TW + 1)
    ) u_div (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .in_v    (det_v),
        .nmag    (det_nmag),
        .neg_in  (det_neg),
        .dmag    (det_dmag),
        .tag_in  ({det_zero, det_tag}),
        .out_v   (div_v),
        .q       (div_q),
        .ovf     (div_ovf),
        .neg_out (div_neg),
        .tag_out (div_tag)
    );

    aim_tail #(
        .W  (W),
        .F  (F),
        .TW (TW + 1)
    ) u_tail (
        .clk    (clk),
        .rst_n  (rst_n),
        .en     (en),
        .in_v   (div_v),
        .q      (div_q),
        .ovf    (div_ovf),
        .neg    (div_neg),
        .tag_in (div_tag),
        .out_v  (out_valid),
        .inv    (inv),
        .shift  (shift)
    );

    assign inv_row0_col0  = inv[0];
    assign inv_row0_col1  = inv[1];
    assign inv_row0_col2  = inv[2];
    assign inv_row0_shift = shift[0];
    assign inv_row1_col0  = inv[3];
    assign inv_row1_col1  = inv[4];
    assign inv_row1_col2  = inv[5];
    assign inv_row1_shift = shift[1];
    assign inv_row2_col0  = inv[6];
    assign inv_row2_col1  = inv[7];
    assign inv_row2_col2  = inv[8];
    assign inv_row2_shift = shift[2];

endmodule

/* tb/sv/affine_matrix_inverse_tb.sv */
// ----------------------------------------------------------------------------
// affine_matrix_inverse_tb
// Self-checking bench for the fixed-point inverse of a 3x4 affine transform.
// ----------------------------------------------------------------------------
// Matrices are pushed through the valid/ready input in bursts with random
// gaps, while the result side stalls on a pattern of its own. For every
// accepted word the bench computes the exact inverse in wide signed
// arithmetic and queues it. The checker compares each returned word, field by
// field, against the oldest queued inverse.
// ----------------------------------------------------------------------------
module affine_matrix_inverse_tb;

    localparam int WORD_BITS = aim_pkg::WORD_BITS;
    localparam int FRAC_BITS = aim_pkg::FRAC_BITS;

    // Pipeline latency used for the final drain, with margin added on top.
    localparam int LATENCY    = WORD_BITS + 10;
    localparam int CYCLE_CAP  = 400000;
    localparam int RAND_ITEMS = 500;

    // Twelve fields in row-major order, translation last in each row.
    typedef logic [11:0][WORD_BITS-1:0] matrix_t;
    // Wide enough for cofactor * 2^(2*FRAC_BITS) with room to spare.
    typedef logic signed [255:0] wide_t;
    typedef logic signed [WORD_BITS-1:0] word_t;

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_ready;
    logic out_valid;
    logic out_ready;
    word_t row0_col0, row0_col1, row0_col2, row0_shift;
    word_t row1_col0, row1_col1, row1_col2, row1_shift;
    word_t row2_col0, row2_col1, row2_col2, row2_shift;
    word_t inv_row0_col0, inv_row0_col1, inv_row0_col2, inv_row0_shift;
    word_t inv_row1_col0, inv_row1_col1, inv_row1_col2, inv_row1_shift;
    word_t inv_row2_col0, inv_row2_col1, inv_row2_col2, inv_row2_shift;

    matrix_t inverse_queue [$];
    matrix_t returned;
    int      mismatches = 0;
    int      cycles = 0;
    int      burst_left;

    affine_matrix_inverse uut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .row0_col0      (row0_col0),
        .row0_col1      (row0_col1),
        .row0_col2      (row0_col2),
        .row0_shift     (row0_shift),
        .row1_col0      (row1_col0),
        .row1_col1      (row1_col1),
        .row1_col2      (row1_col2),
        .row1_shift     (row1_shift),
        .row2_col0      (row2_col0),
        .row2_col1      (row2_col1),
        .row2_col2      (row2_col2),
        .row2_shift     (row2_shift),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .inv_row0_col0  (inv_row0_col0),
        .inv_row0_col1  (inv_row0_col1),
        .inv_row0_col2  (inv_row0_col2),
        .inv_row0_shift (inv_row0_shift),
        .inv_row1_col0  (inv_row1_col0),
        .inv_row1_col1  (inv_row1_col1),
        .inv_row1_col2  (inv_row1_col2),
        .inv_row1_shift (inv_row1_shift),
        .inv_row2_col0  (inv_row2_col0),
        .inv_row2_col1  (inv_row2_col1),
        .inv_row2_col2  (inv_row2_col2),
        .inv_row2_shift (inv_row2_shift)
    );

    // The first element of a packed concatenation is the top index, so the
    // list runs from the last field down to row 0 column 0.
    assign returned = {inv_row2_shift, inv_row2_col2, inv_row2_col1, inv_row2_col0,
                       inv_row1_shift, inv_row1_col2, inv_row1_col1, inv_row1_col0,
                       inv_row0_shift, inv_row0_col2, inv_row0_col1, inv_row0_col0};

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Clamp an exact value to the signed word range.
    function automatic word_t clamp_word(input wide_t v);
        wide_t hi;
        wide_t lo;
        hi = (wide_t'(1) <<< (WORD_BITS - 1)) - 1;
        lo = -hi - 1;
        if (v > hi)
            return word_t'(hi);
        if (v < lo)
            return word_t'(lo);
        return word_t'(v);
    endfunction

    // Exact inverse: adjugate over determinant for the linear part, then the
    // negated translation pushed through the already clamped inverse rows.
    // SystemVerilog division of signed operands truncates toward zero.
    function automatic matrix_t affine_inverse(input matrix_t m);
        wide_t   a [3][4];
        wide_t   cof [3][3];
        wide_t   det;
        wide_t   dot;
        word_t   lin [3][3];
        matrix_t r;
        for (int i = 0; i < 3; i++)
            for (int j = 0; j < 4; j++)
                a[i][j] = wide_t'($signed(m[i*4+j]));
        cof[0][0] = a[1][1]*a[2][2] - a[2][1]*a[1][2];
        cof[0][1] = a[2][1]*a[0][2] - a[0][1]*a[2][2];
        cof[0][2] = a[0][1]*a[1][2] - a[1][1]*a[0][2];
        cof[1][0] = a[2][0]*a[1][2] - a[1][0]*a[2][2];
        cof[1][1] = a[0][0]*a[2][2] - a[2][0]*a[0][2];
        cof[1][2] = a[1][0]*a[0][2] - a[0][0]*a[1][2];
        cof[2][0] = a[1][0]*a[2][1] - a[2][0]*a[1][1];
        cof[2][1] = a[2][0]*a[0][1] - a[0][0]*a[2][1];
        cof[2][2] = a[0][0]*a[1][1] - a[1][0]*a[0][1];
        det = a[0][0]*cof[0][0] + a[0][1]*cof[1][0] + a[0][2]*cof[2][0];
        r = '0;
        if (det == 0)
            return r;
        for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++)
            begin
                lin[i][j] = clamp_word((cof[i][j] <<< (2*FRAC_BITS)) / det);
                r[i*4+j] = lin[i][j];
            end
        for (int i = 0; i < 3; i++)
        begin
            dot = a[0][3]*wide_t'(lin[i][0]) + a[1][3]*wide_t'(lin[i][1])
                + a[2][3]*wide_t'(lin[i][2]);
            r[i*4+3] = clamp_word((-dot) / (wide_t'(1) <<< FRAC_BITS));
        end
        return r;
    endfunction

    task automatic report_mismatch(input int field, input word_t got, input word_t want);
        $display("[%0d] field row %0d col %0d: got %0d, expected %0d",
                 cycles, field / 4, field % 4, got, want);
        mismatches++;
    endtask

    // Sends one word, leaving in_valid high so that a following word in the
    // same burst goes out on the next cycle. Gaps fall between bursts.
    task automatic send_matrix(input matrix_t m);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        {row2_shift, row2_col2, row2_col1, row2_col0,
         row1_shift, row1_col2, row1_col1, row1_col0,
         row0_shift, row0_col2, row0_col1, row0_col0} <= m;
        in_valid <= 1'b1;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        inverse_queue.push_back(affine_inverse(m));
        burst_left--;
    endtask

    task automatic hold_until_drained();
        in_valid <= 1'b0;
        burst_left = 0;
        while (inverse_queue.size() != 0)
            @(posedge clk);
    endtask

    function automatic matrix_t linear_diag(input word_t d0, input word_t d1, input word_t d2,
                                            input word_t t0, input word_t t1,
                                            input word_t t2);
        matrix_t m;
        m = '0;
        m[0] = d0;  m[5] = d1;  m[10] = d2;
        m[3] = t0;  m[7] = t1;  m[11] = t2;
        return m;
    endfunction

    // Extremes, saturation in both directions, singular cases and
    // truncation toward zero on both signs.
    task automatic test_directed();
        localparam word_t ONE  = word_t'(1) <<< FRAC_BITS;
        localparam word_t WMAX = {1'b0, {(WORD_BITS-1){1'b1}}};
        localparam word_t WMIN = {1'b1, {(WORD_BITS-1){1'b0}}};
        matrix_t m;
        send_matrix(linear_diag(ONE, ONE, ONE, 0, 0, 0));
        send_matrix(linear_diag(ONE, ONE, ONE, WMAX, WMIN, -1));
        send_matrix('0);
        send_matrix({12{WMAX}});
        send_matrix({12{WMIN}});
        send_matrix(linear_diag(1, 1, 1, 1, -1, WMAX));
        send_matrix(linear_diag(-1, -1, -1, WMIN, 1, 0));
        send_matrix(linear_diag(WMAX, WMAX, WMAX, WMIN, WMIN, WMIN));
        send_matrix(linear_diag(WMIN, WMIN, WMIN, WMAX, WMAX, WMAX));
        send_matrix(linear_diag(3*ONE, -3*ONE, 7*ONE, 5*ONE, -5*ONE, ONE + 1));
        send_matrix(linear_diag(WMAX, 1, WMIN, WMAX, WMAX, WMIN));
        // Row permutation with a sign flip.
        m = '0;
        m[1] = ONE;  m[6] = -ONE;  m[8] = ONE;  m[3] = 2*ONE;  m[11] = -ONE;
        send_matrix(m);
        // Two equal rows: nonzero entries, zero determinant.
        m = {word_t'(9), word_t'(3*ONE), word_t'(-ONE), word_t'(2*ONE),
             word_t'(4), word_t'(ONE), word_t'(ONE), word_t'(ONE),
             word_t'(7), word_t'(3*ONE), word_t'(-ONE), word_t'(2*ONE)};
        send_matrix(m);
        send_matrix({6{word_t'(32'h5555_5555), word_t'(32'hAAAA_AAAA)}});
        send_matrix(linear_diag(32'h5555_5555, 32'hAAAA_AAAA, 32'h0001_0001,
                                32'hAAAA_AAAA, 32'h5555_5555, 32'hFFFF_0000));
        hold_until_drained();
    endtask

    function automatic word_t near_value(input int mag);
        return word_t'($signed($urandom_range(0, 2*mag)) - mag);
    endfunction

    // Mostly well-conditioned transforms whose inverse stays in range, with
    // fully random, singular and very small matrices mixed in.
    function automatic matrix_t random_matrix();
        matrix_t m;
        int      kind;
        kind = $urandom_range(0, 99);
        for (int k = 0; k < 12; k++)
            m[k] = $urandom;
        if (kind < 60)
        begin
            for (int i = 0; i < 3; i++)
            begin
                for (int j = 0; j < 3; j++)
                    m[i*4+j] = near_value(1 << (FRAC_BITS - 1));
                m[i*5] = word_t'(($urandom_range(1, 8) << FRAC_BITS)
                                 + $urandom_range(0, (1 << FRAC_BITS) - 1));
                if ($urandom_range(0, 1))
                    m[i*5] = -m[i*5];
                if ($urandom_range(0, 3) != 0)
                    m[i*4+3] = near_value(1 << (FRAC_BITS + 8));
            end
        end
        else if (kind < 72)
        begin
            // Two equal rows, or one random linear entry zeroed in each row.
            if ($urandom_range(0, 1))
                for (int j = 0; j < 3; j++)
                    m[8+j] = m[j];
            else
                for (int i = 0; i < 3; i++)
                    m[i*4 + $urandom_range(0, 2)] = '0;
        end
        else if (kind < 87)
        begin
            for (int i = 0; i < 3; i++)
                for (int j = 0; j < 3; j++)
                    m[i*4+j] = near_value(64);
        end
        return m;
    endfunction

    task automatic test_random(input int count);
        for (int n = 0; n < count; n++)
        begin
            send_matrix(random_matrix());
            // Once half way, let the pipeline empty completely before going on.
            if (n == count / 2)
                hold_until_drained();
        end
        in_valid <= 1'b0;
    endtask

    // Result side: phases of free flow, random stalls and heavy stalls.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else
        begin
            case ((cycles / 97) % 3)
                0:       out_ready <= 1'b1;
                1:       out_ready <= 1'($urandom_range(0, 1));
                default: out_ready <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    // Checker: every word taken from the block must match the oldest inverse.
    always @(posedge clk)
    begin
        matrix_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (inverse_queue.size() == 0)
            begin
                $display("[%0d] result word with nothing expected", cycles);
                mismatches++;
            end
            else
            begin
                want = inverse_queue.pop_front();
                for (int k = 0; k < 12; k++)
                    if (returned[k] !== want[k])
                        report_mismatch(k, returned[k], want[k]);
            end
        end
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_CAP)
        begin
            $display("[%0d] timeout", cycles);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial
    begin
        rst_n      = 1'b0;
        in_valid   = 1'b0;
        burst_left = 0;
        {row2_shift, row2_col2, row2_col1, row2_col0,
         row1_shift, row1_col2, row1_col1, row1_col0,
         row0_shift, row0_col2, row0_col1, row0_col0} = '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_random(RAND_ITEMS);
        hold_until_drained();
        repeat (LATENCY + 20) @(posedge clk);
        if (mismatches == 0 && inverse_queue.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
